FILE: hw/rtl/lgpi_pkg.sv
// ----------------------------------------------------------------------------
// lgpi_pkg: shared types and constants of the layered grid interpolator
// Grid geometry, store layouts, codes, channel payloads and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package lgpi_pkg;

	// Grid and store geometry
	localparam int GRID_COLUMNS      = 105;
	localparam int GRID_ROWS         = 42;
	localparam int LAYER_STORE_DEPTH = 32768;
	localparam int MAX_LAYERS        = 16;

	localparam int NODE_COUNT = (GRID_COLUMNS + 1) * (GRID_ROWS + 1);
	localparam int NODE_AW    = $clog2(NODE_COUNT);
	localparam int LAYER_AW   = $clog2(LAYER_STORE_DEPTH);
	localparam int NODE_W     = 24 + 5 + LAYER_AW;
	localparam int LAYER_W    = 72;

	// One cell is 250 m in 1/256 m units
	localparam int CELL_SIZE = 64000;
	localparam int SPAN_X    = GRID_COLUMNS * CELL_SIZE;
	localparam int SPAN_Y    = GRID_ROWS * CELL_SIZE;

	// Reciprocals: ceil(2^30/125) and ceil(2^30/5)
	localparam logic [23:0] RECIP125 = 24'd8589935;
	localparam logic [27:0] RECIP5   = 28'd214748365;

	// Fallback values: 1000 m/s, 2000 m/s, 2200 kg/m^3
	localparam logic [23:0] FALLBACK_VS  = 24'd256000;
	localparam logic [23:0] FALLBACK_VP  = 24'd512000;
	localparam logic [23:0] FALLBACK_RHO = 24'd563200;

	// Function codes
	localparam logic [1:0] FUNC_NODE  = 2'd0;
	localparam logic [1:0] FUNC_LAYER = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	// Query status codes
	localparam logic [1:0] QS_ABOVE    = 2'd0;
	localparam logic [1:0] QS_OUTSIDE  = 2'd1;
	localparam logic [1:0] QS_INTERP   = 2'd2;
	localparam logic [1:0] QS_FALLBACK = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_DEPTH    = 3'd2;
	localparam logic [2:0] REG_OUT_VS   = 3'd3;
	localparam logic [2:0] REG_OUT_VP   = 3'd4;
	localparam logic [2:0] REG_OUT_RHO  = 3'd5;

	typedef struct packed {
		logic        [1:0]  func;
		logic        [14:0] entry_index;
		logic        [31:0] pos_x;
		logic        [31:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [23:0] node_elevation;
		logic        [4:0]  node_layer_count;
		logic        [15:0] node_first_layer;
		logic        [23:0] layer_shear_velocity;
		logic        [23:0] layer_density;
		logic        [23:0] layer_thickness;
	} in_item_t;

	typedef struct packed {
		logic [23:0] shear_velocity;
		logic [23:0] pressure_velocity;
		logic [23:0] density;
		logic [1:0]  query_status;
	} out_item_t;

	typedef struct packed {
		logic [31:0] origin_x;
		logic [31:0] origin_y;
		logic [22:0] depth_limit;
		logic [23:0] out_vs;
		logic [23:0] out_vp;
		logic [23:0] out_rho;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_LOC2, ST_LOC3, ST_LOC4, ST_NODE_RD, ST_NODE_LAT,
		ST_MAC_E, ST_ZCORR, ST_WALK_START, ST_WALK_CHK, ST_VP1, ST_VP2,
		ST_MAC_V, ST_FINAL, ST_OUT
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_WRITE, OP_LOC1, OP_LOC2, OP_LOC3, OP_LOC4,
		OP_NODE_RD, OP_NODE_LAT, OP_MAC, OP_ZCORR, OP_WALK_START, OP_WALK_CHK,
		OP_NOLAYER, OP_VP1, OP_VP2, OP_FINAL, OP_OUT
	} dp_op_t;

	typedef enum logic [1:0] {
		MAC_ELEV, MAC_VS, MAC_VP, MAC_RHO
	} mac_sel_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] corner;
		mac_sel_t   mac_sel;
		logic       mac_hi;
		logic [1:0] kind;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       above;
		logic       outside;
		logic       cnt_zero;
		logic       match;
		logic       last_layer;
		logic       out_busy;
	} dp_status_t;

	// floor(t/125) for t < 2^23
	function automatic logic [16:0] div125(input logic [22:0] t);
		logic [46:0] p;
		p = 47'(t) * 47'(RECIP125);
		return p[46:30];
	endfunction

endpackage

FILE: hw/rtl/lgpi_ram.sv
// ----------------------------------------------------------------------------
// lgpi_ram: generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module lgpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: hw/rtl/lgpi_ctrl.sv
// ----------------------------------------------------------------------------
// lgpi_ctrl: transaction sequencer
// Steps each query through locate, elevation pass, per-corner layer walk and
// result formation, and each store write, by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module lgpi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lgpi_pkg::dp_status_t status,
	output lgpi_pkg::dp_cmd_t    cmd
);
	import lgpi_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [1:0]  corner_q, corner_d;
	logic [2:0]  mac_cnt_q, mac_cnt_d;
	logic [1:0]  kind_q, kind_d;

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			corner_q  <= 2'd0;
			mac_cnt_q <= 3'd0;
			kind_q    <= QS_ABOVE;
		end else begin
			state_q   <= state_d;
			corner_q  <= corner_d;
			mac_cnt_q <= mac_cnt_d;
			kind_q    <= kind_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		corner_d    = corner_q;
		mac_cnt_d   = mac_cnt_q;
		kind_d      = kind_q;
		in_ready    = 1'b0;
		cmd.op      = OP_NONE;
		cmd.corner  = corner_q;
		cmd.mac_sel = MAC_ELEV;
		cmd.mac_hi  = mac_cnt_q[0];
		cmd.kind    = kind_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.func == FUNC_NODE || status.func == FUNC_LAYER) begin
					cmd.op  = OP_WRITE;
					state_d = ST_IDLE;
				end else if (status.func == FUNC_QUERY) begin
					cmd.op  = OP_LOC1;
					state_d = ST_LOC2;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_LOC2: begin
				cmd.op = OP_LOC2;
				if (status.above) begin
					kind_d  = QS_ABOVE;
					state_d = ST_OUT;
				end else if (status.outside) begin
					kind_d  = QS_OUTSIDE;
					state_d = ST_OUT;
				end else begin
					kind_d  = QS_INTERP;
					state_d = ST_LOC3;
				end
			end
			ST_LOC3: begin
				cmd.op  = OP_LOC3;
				state_d = ST_LOC4;
			end
			ST_LOC4: begin
				cmd.op   = OP_LOC4;
				corner_d = 2'd0;
				state_d  = ST_NODE_RD;
			end
			ST_NODE_RD: begin
				cmd.op  = OP_NODE_RD;
				state_d = ST_NODE_LAT;
			end
			ST_NODE_LAT: begin
				cmd.op    = OP_NODE_LAT;
				mac_cnt_d = 3'd0;
				state_d   = ST_MAC_E;
			end
			// Elevation: low then high half of the corner weight
			ST_MAC_E: begin
				cmd.op    = OP_MAC;
				mac_cnt_d = mac_cnt_q + 3'd1;
				if (mac_cnt_q[0]) begin
					corner_d = corner_q + 2'd1;
					state_d  = (corner_q == 2'd3) ? ST_ZCORR : ST_NODE_RD;
				end
			end
			ST_ZCORR: begin
				cmd.op   = OP_ZCORR;
				corner_d = 2'd0;
				state_d  = ST_WALK_START;
			end
			ST_WALK_START: begin
				mac_cnt_d = 3'd0;
				if (status.cnt_zero) begin
					cmd.op  = OP_NOLAYER;
					state_d = ST_MAC_V;
				end else begin
					cmd.op  = OP_WALK_START;
					state_d = ST_WALK_CHK;
				end
			end
			// One layer per cycle; next read is issued speculatively
			ST_WALK_CHK: begin
				cmd.op = OP_WALK_CHK;
				if (status.match) begin
					state_d = ST_VP1;
				end else if (status.last_layer) begin
					state_d = ST_MAC_V;
				end
			end
			ST_VP1: begin
				cmd.op  = OP_VP1;
				state_d = ST_VP2;
			end
			ST_VP2: begin
				cmd.op  = OP_VP2;
				state_d = ST_MAC_V;
			end
			// vs, vp, rho: two halves each
			ST_MAC_V: begin
				cmd.op      = OP_MAC;
				cmd.mac_sel = mac_sel_t'(mac_cnt_q[2:1] + 2'd1);
				mac_cnt_d   = mac_cnt_q + 3'd1;
				if (mac_cnt_q == 3'd5) begin
					corner_d = corner_q + 2'd1;
					state_d  = (corner_q == 2'd3) ? ST_FINAL : ST_WALK_START;
				end
			end
			ST_FINAL: begin
				cmd.op  = OP_FINAL;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!status.out_busy) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/lgpi_dp.sv
// ----------------------------------------------------------------------------
// lgpi_dp: interpolator datapath
// Node and layer stores, cell location, corner weights, one shared
// multiply-accumulate, layer walk and the output register.
// ----------------------------------------------------------------------------
module lgpi_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lgpi_pkg::dp_cmd_t    cmd,
	output lgpi_pkg::dp_status_t status,
	input  lgpi_pkg::cfg_t       cfg,
	input  lgpi_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lgpi_pkg::out_item_t  out_item
);
	import lgpi_pkg::*;

	in_item_t in_q;

	logic [32:0] dx_full, dy_full;
	logic [22:0] dx_q, dy_q;
	logic        above_q, outside_q;
	logic [9:0]  cx_q, cy_q;
	logic [22:0] fracx, fracy;
	logic [23:0] numx_q, numy_q;
	logic [16:0] wx_q, wy_q;
	logic [NODE_AW-1:0] node0_q;

	logic signed [23:0] elev_q [4];
	logic [4:0]          cnt_q [4];
	logic [LAYER_AW-1:0] start_q [4];
	logic [32:0]         w_q [4];
	logic [57:0]         acc_q [4];

	logic signed [24:0] zc_q;
	logic signed [25:0] lim_q;
	logic [28:0]        lsum_q;
	logic [28:0]        lsum;
	logic [4:0]         k_q;
	logic [23:0]        lvs_q, lrho_q;
	logic [24:0]        lvp_q;
	logic [55:0]        vp_prod_q;
	logic [27:0]        vp_num;
	logic [23:0]        rvs_q, rvp_q, rrho_q;
	logic               fb_q;
	out_item_t          out_q;
	logic               out_valid_q;

	logic               node_we, layer_we;
	logic [NODE_AW-1:0] node_addr;
	logic [LAYER_AW-1:0] layer_addr;
	logic [NODE_W-1:0]  node_wdata, node_rdata;
	logic [LAYER_W-1:0] layer_wdata, layer_rdata;
	logic [4:0]         cnt_sat;
	logic [15:0]        first_m1;

	logic [16:0] ax, by;
	logic [16:0] mac_half;
	logic [24:0] mac_val;
	logic [41:0] mac_prod;
	logic [57:0] mac_add;
	logic [57:0] er;
	logic signed [23:0] zi;
	logic [57:0] rv, rp, rr;
	logic        match;

	// Stores
	assign cnt_sat    = (in_q.node_layer_count > 5'(MAX_LAYERS)) ?
		5'(MAX_LAYERS) : in_q.node_layer_count;
	assign first_m1   = in_q.node_first_layer - 16'd1;
	assign node_wdata = {in_q.node_elevation, cnt_sat, first_m1[LAYER_AW-1:0]};
	assign layer_wdata = {in_q.layer_shear_velocity, in_q.layer_density,
		in_q.layer_thickness};
	assign node_we  = (cmd.op == OP_WRITE) && (in_q.func == FUNC_NODE) &&
		(32'(in_q.entry_index) < NODE_COUNT);
	assign layer_we = (cmd.op == OP_WRITE) && (in_q.func == FUNC_LAYER) &&
		(32'(in_q.entry_index) < LAYER_STORE_DEPTH);

	// Node address per corner, or the entry index on a write
	always_comb begin
		if (cmd.op == OP_WRITE) begin
			node_addr = in_q.entry_index[NODE_AW-1:0];
		end else begin
			case (cmd.corner)
				2'd0: node_addr = node0_q;
				2'd1: node_addr = node0_q + NODE_AW'(1);
				2'd2: node_addr = node0_q + NODE_AW'(GRID_COLUMNS + 2);
				2'd3: node_addr = node0_q + NODE_AW'(GRID_COLUMNS + 1);
				default: node_addr = node0_q;
			endcase
		end
	end

	// Layer address: entry index on a write, top layer on walk start, then the one after k
	always_comb begin
		if (cmd.op == OP_WRITE) begin
			layer_addr = in_q.entry_index[LAYER_AW-1:0];
		end else if (cmd.op == OP_WALK_START) begin
			layer_addr = start_q[cmd.corner];
		end else begin
			layer_addr = start_q[cmd.corner] + LAYER_AW'(k_q) + LAYER_AW'(1);
		end
	end

	lgpi_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.addr  (node_addr),
		.wdata (node_wdata),
		.rdata (node_rdata)
	);

	lgpi_ram #(.WIDTH(LAYER_W), .DEPTH(LAYER_STORE_DEPTH)) u_layer_ram (
		.clk   (clk),
		.we    (layer_we),
		.addr  (layer_addr),
		.wdata (layer_wdata),
		.rdata (layer_rdata)
	);

	// Locate helpers
	assign dx_full = {1'b0, in_q.pos_x} - {1'b0, cfg.origin_x};
	assign dy_full = {1'b0, in_q.pos_y} - {1'b0, cfg.origin_y};
	assign fracx   = dx_q - 23'(cx_q) * 23'(CELL_SIZE);
	assign fracy   = dy_q - 23'(cy_q) * 23'(CELL_SIZE);

	// Corner axis weights
	assign ax = (cmd.corner == 2'd1 || cmd.corner == 2'd2) ? wx_q : 17'd65536 - wx_q;
	assign by = (cmd.corner == 2'd2 || cmd.corner == 2'd3) ? wy_q : 17'd65536 - wy_q;

	// Shared MAC: half of the corner weight times one value
	always_comb begin
		case (cmd.mac_sel)
			MAC_ELEV: mac_val = {1'b0, ~elev_q[cmd.corner][23], elev_q[cmd.corner][22:0]};
			MAC_VS:   mac_val = {1'b0, lvs_q};
			MAC_VP:   mac_val = lvp_q;
			MAC_RHO:  mac_val = {1'b0, lrho_q};
			default:  mac_val = 25'd0;
		endcase
	end
	assign mac_half = cmd.mac_hi ? w_q[cmd.corner][32:16] : {1'b0, w_q[cmd.corner][15:0]};
	assign mac_prod = 42'(mac_half) * 42'(mac_val);
	assign mac_add  = cmd.mac_hi ? {mac_prod, 16'd0} : 58'(mac_prod);

	// Elevation correction and layer compare
	assign er     = acc_q[MAC_ELEV] + 58'h0_8000_0000;
	assign zi     = {~er[55], er[54:32]};
	assign lsum   = lsum_q + 29'(layer_rdata[23:0]);
	assign match  = $signed({1'b0, lsum}) > 30'(lim_q);
	assign vp_num = 28'(lvs_q) * 28'd9 + 28'd2;

	// Rounded sums
	assign rv = acc_q[MAC_VS] + 58'h0_8000_0000;
	assign rp = acc_q[MAC_VP] + 58'h0_8000_0000;
	assign rr = acc_q[MAC_RHO] + 58'h0_8000_0000;

	// Payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				in_q <= in_item;
			end
			OP_LOC1: begin
				dx_q      <= dx_full[22:0];
				dy_q      <= dy_full[22:0];
				above_q   <= !in_q.pos_z[23] && (in_q.pos_z != 24'sd0);
				outside_q <= dx_full[32] || (dx_full[31:0] > 32'(SPAN_X)) ||
					dy_full[32] || (dy_full[31:0] > 32'(SPAN_Y)) ||
					($signed({in_q.pos_z[23], in_q.pos_z}) <
					-$signed({2'b00, cfg.depth_limit}));
			end
			OP_LOC2: begin
				cx_q <= (dx_q == 23'(SPAN_X)) ? 10'(GRID_COLUMNS - 1) :
					10'(div125({9'd0, dx_q[22:9]}));
				cy_q <= (dy_q == 23'(SPAN_Y)) ? 10'(GRID_ROWS - 1) :
					10'(div125({9'd0, dy_q[22:9]}));
			end
			OP_LOC3: begin
				numx_q <= {fracx[15:0], 8'd0} + 24'd125;
				numy_q <= {fracy[15:0], 8'd0} + 24'd125;
			end
			OP_LOC4: begin
				wx_q    <= div125(numx_q[23:1]);
				wy_q    <= div125(numy_q[23:1]);
				node0_q <= NODE_AW'(32'(cy_q) * (GRID_COLUMNS + 1) + 32'(cx_q));
				for (int i = 0; i < 4; i++) begin
					acc_q[i] <= 58'd0;
				end
			end
			OP_NODE_LAT: begin
				elev_q[cmd.corner]  <= node_rdata[NODE_W-1 -: 24];
				cnt_q[cmd.corner]   <= node_rdata[LAYER_AW +: 5];
				start_q[cmd.corner] <= node_rdata[LAYER_AW-1:0];
				w_q[cmd.corner]     <= 33'(34'(ax) * 34'(by));
			end
			OP_MAC: begin
				acc_q[cmd.mac_sel] <= acc_q[cmd.mac_sel] + mac_add;
			end
			OP_ZCORR: begin
				zc_q <= 25'(in_q.pos_z) + 25'(zi);
			end
			OP_WALK_START: begin
				k_q    <= 5'd0;
				lsum_q <= 29'd0;
				lim_q  <= 26'(elev_q[cmd.corner]) - 26'(zc_q);
			end
			OP_WALK_CHK: begin
				k_q    <= k_q + 5'd1;
				lsum_q <= lsum;
				lvs_q  <= layer_rdata[71:48];
				lrho_q <= layer_rdata[47:24];
				lvp_q  <= {layer_rdata[71:48], 1'b0};
			end
			OP_NOLAYER: begin
				lvs_q  <= 24'd0;
				lvp_q  <= 25'd0;
				lrho_q <= 24'd0;
			end
			OP_VP1: begin
				vp_prod_q <= 56'(vp_num) * 56'(RECIP5);
			end
			OP_VP2: begin
				lvp_q <= vp_prod_q[54:30];
			end
			OP_FINAL: begin
				fb_q   <= (rv[57:32] == 26'd0) || (rp[57:32] == 26'd0) ||
					(rr[57:32] == 26'd0);
				rvs_q  <= (|rv[57:56]) ? 24'hFFFFFF : rv[55:32];
				rvp_q  <= (|rp[57:56]) ? 24'hFFFFFF : rp[55:32];
				rrho_q <= (|rr[57:56]) ? 24'hFFFFFF : rr[55:32];
			end
			OP_OUT: begin
				case (cmd.kind)
					QS_ABOVE: begin
						out_q <= '{24'd0, 24'd0, 24'd0, QS_ABOVE};
					end
					QS_OUTSIDE: begin
						out_q <= '{cfg.out_vs, cfg.out_vp, cfg.out_rho, QS_OUTSIDE};
					end
					default: begin
						if (fb_q) begin
							out_q <= '{FALLBACK_VS, FALLBACK_VP, FALLBACK_RHO, QS_FALLBACK};
						end else begin
							out_q <= '{rvs_q, rvp_q, rrho_q, QS_INTERP};
						end
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Status to the controller
	assign status.func       = in_q.func;
	assign status.above      = above_q;
	assign status.outside    = outside_q;
	assign status.cnt_zero   = (cnt_q[cmd.corner] == 5'd0);
	assign status.match      = match;
	assign status.last_layer = ((k_q + 5'd1) == cnt_q[cmd.corner]);
	assign status.out_busy   = out_valid_q && !out_ready;

endmodule

FILE: hw/rtl/layered_grid_property_interpolator_core.sv
// ----------------------------------------------------------------------------
// layered_grid_property_interpolator_core: layered grid property interpolator
// Node and layer writes, bilinear query of velocity and density, APB config.
// ----------------------------------------------------------------------------
// Write transaction: no result. Query above the surface or outside the grid:
// skips the interpolation and returns a status result. Interpolated query: its
// time grows with the layers walked at each of the four corners and is set by
// the single-port layer store read once per layer and the shared MAC.
// One transaction at a time.
// Reset is asynchronous: control and config registers go to their defaults.
module layered_grid_property_interpolator_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lgpi_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output lgpi_pkg::out_item_t out_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import lgpi_pkg::*;

	cfg_t       cfg_q;
	dp_cmd_t    cmd;
	dp_status_t status;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x    <= 32'd99456000;
			cfg_q.origin_y    <= 32'd1161318400;
			cfg_q.depth_limit <= 23'd76800;
			cfg_q.out_vs      <= 24'd819200;
			cfg_q.out_vp      <= 24'd1408000;
			cfg_q.out_rho     <= 24'd716800;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_ORIGIN_X: cfg_q.origin_x    <= pwdata;
				REG_ORIGIN_Y: cfg_q.origin_y    <= pwdata;
				REG_DEPTH:    cfg_q.depth_limit <= pwdata[22:0];
				REG_OUT_VS:   cfg_q.out_vs      <= pwdata[23:0];
				REG_OUT_VP:   cfg_q.out_vp      <= pwdata[23:0];
				REG_OUT_RHO:  cfg_q.out_rho     <= pwdata[23:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back
	always_comb begin
		case (reg_idx)
			REG_ORIGIN_X: prdata = cfg_q.origin_x;
			REG_ORIGIN_Y: prdata = cfg_q.origin_y;
			REG_DEPTH:    prdata = {9'd0, cfg_q.depth_limit};
			REG_OUT_VS:   prdata = {8'd0, cfg_q.out_vs};
			REG_OUT_VP:   prdata = {8'd0, cfg_q.out_vp};
			REG_OUT_RHO:  prdata = {8'd0, cfg_q.out_rho};
			default:      prdata = 32'd0;
		endcase
	end

	lgpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lgpi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg       (cfg_q),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the layered grid property interpolator
// Fills node and layer stores, then runs directed and random point queries
// over several register settings. A built-in predictor models every
// transaction, and a monitor compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import lgpi_pkg::*;

	localparam int ROW_PITCH  = GRID_COLUMNS + 1;
	localparam int END_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	layered_grid_property_interpolator_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Register copies, reset values
	logic [31:0] cfg_origin_x = 32'd99456000;
	logic [31:0] cfg_origin_y = 32'd1161318400;
	logic [22:0] cfg_depth    = 23'd76800;
	logic [23:0] cfg_out_vs   = 24'd819200;
	logic [23:0] cfg_out_vp   = 24'd1408000;
	logic [23:0] cfg_out_rho  = 24'd716800;

	// Predictor stores, updated on acceptance
	longint      node_elev  [NODE_COUNT];
	int unsigned node_cnt   [NODE_COUNT];
	int unsigned node_start [NODE_COUNT];
	int unsigned lay_vs  [LAYER_STORE_DEPTH];
	int unsigned lay_rho [LAYER_STORE_DEPTH];
	int unsigned lay_th  [LAYER_STORE_DEPTH];

	// Shadow of what stimulus has written so far, in generation order
	bit          gen_node_ok [NODE_COUNT];
	int unsigned gen_cnt     [NODE_COUNT];
	int unsigned gen_start   [NODE_COUNT];
	bit          gen_layer_ok[LAYER_STORE_DEPTH];

	in_item_t  pending_items[$];
	out_item_t predicted_props[$];

	int errors = 0;
	int status_seen[4];
	int s_idle_pct = 12;
	int r_idle_pct = 57;
	bit hold_toggle = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// One axis of the grid search; 0 when the point lies outside
	function automatic bit locate_axis(input longint unsigned pos, input longint unsigned org,
			input longint unsigned cells, output int unsigned cell_idx,
			output longint unsigned w);
		longint unsigned span, d;
		span = cells * CELL_SIZE;
		cell_idx = 0;
		w = 0;
		if (pos < org || pos - org > span)
			return 1'b0;
		d = pos - org;
		if (d == span) begin
			cell_idx = 32'(cells - 1);
			w = 65536;
		end else begin
			cell_idx = 32'(d / CELL_SIZE);
			w = ((d % CELL_SIZE) * 65536 + CELL_SIZE / 2) / CELL_SIZE;
		end
		return 1'b1;
	endfunction

	// Applies a transaction to the stores; 1 and the properties for a query
	function automatic bit interpolate_point(input in_item_t it, output out_item_t r);
		longint z, zi, acc;
		int unsigned col, row, nd[4], a, k;
		longint unsigned wx, wy, w[4], esum, svs, svp, srho, vs, vp, rho;
		longint unsigned lvs, lvp, lrho;
		bit done;
		r = '0;
		case (it.func)
			FUNC_NODE: begin
				if (it.entry_index < NODE_COUNT) begin
					node_elev[it.entry_index]  = longint'(it.node_elevation);
					node_cnt[it.entry_index]   = (it.node_layer_count > MAX_LAYERS) ?
						MAX_LAYERS : it.node_layer_count;
					node_start[it.entry_index] = 16'(it.node_first_layer - 16'd1);
				end
				return 1'b0;
			end
			FUNC_LAYER: begin
				if (it.entry_index < LAYER_STORE_DEPTH) begin
					lay_vs[it.entry_index]  = it.layer_shear_velocity;
					lay_rho[it.entry_index] = it.layer_density;
					lay_th[it.entry_index]  = it.layer_thickness;
				end
				return 1'b0;
			end
			FUNC_QUERY: ;
			default: return 1'b0;
		endcase
		z = longint'(it.pos_z);
		if (z > 0) begin
			r.query_status = QS_ABOVE;
			return 1'b1;
		end
		if (!locate_axis(it.pos_x, cfg_origin_x, GRID_COLUMNS, col, wx) ||
				!locate_axis(it.pos_y, cfg_origin_y, GRID_ROWS, row, wy) ||
				z < -longint'(cfg_depth)) begin
			r = '{cfg_out_vs, cfg_out_vp, cfg_out_rho, QS_OUTSIDE};
			return 1'b1;
		end
		nd[0] = row * ROW_PITCH + col;
		nd[1] = nd[0] + 1;
		nd[2] = nd[1] + ROW_PITCH;
		nd[3] = nd[0] + ROW_PITCH;
		w[0] = (65536 - wx) * (65536 - wy);
		w[1] = wx * (65536 - wy);
		w[2] = wx * wy;
		w[3] = (65536 - wx) * wy;
		// Elevation at the point corrects the depth
		esum = 0;
		for (int i = 0; i < 4; i++)
			esum += w[i] * longint'(node_elev[nd[i]] + 8388608);
		zi = longint'((esum + 64'h80000000) >> 32) - 8388608;
		z += zi;
		// Walk each corner's layers down to the corrected depth
		svs = 0;
		svp = 0;
		srho = 0;
		for (int i = 0; i < 4; i++) begin
			acc = 0;
			lvs = 0;
			lvp = 0;
			lrho = 0;
			done = 1'b0;
			for (k = 0; k < node_cnt[nd[i]] && !done; k++) begin
				a = (node_start[nd[i]] + k) % LAYER_STORE_DEPTH;
				acc += lay_th[a];
				lvs = lay_vs[a];
				lrho = lay_rho[a];
				if (z > node_elev[nd[i]] - acc) begin
					lvp = (lvs * 9 + 2) / 5;
					done = 1'b1;
				end else begin
					lvp = lvs * 2;
				end
			end
			svs += w[i] * lvs;
			svp += w[i] * lvp;
			srho += w[i] * lrho;
		end
		vs = (svs + 64'h80000000) >> 32;
		vp = (svp + 64'h80000000) >> 32;
		rho = (srho + 64'h80000000) >> 32;
		if (vs == 0 || vp == 0 || rho == 0) begin
			r = '{FALLBACK_VS, FALLBACK_VP, FALLBACK_RHO, QS_FALLBACK};
			return 1'b1;
		end
		r.shear_velocity    = (vs > 24'hFFFFFF) ? 24'hFFFFFF : vs[23:0];
		r.pressure_velocity = (vp > 24'hFFFFFF) ? 24'hFFFFFF : vp[23:0];
		r.density           = (rho > 24'hFFFFFF) ? 24'hFFFFFF : rho[23:0];
		r.query_status      = QS_INTERP;
		return 1'b1;
	endfunction

	// Sender: presents queued transactions, random gaps
	always @(posedge clk) begin
		out_item_t pred;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (interpolate_point(in_item, pred))
					predicted_props.push_back(pred);
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
					in_valid <= 1'b1;
					in_item <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks results, random stalls and one long hold-off
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (predicted_props.size() == 0) begin
					report_mismatch("unexpected result status", out_item.query_status, 0);
				end else begin
					want = predicted_props.pop_front();
					status_seen[out_item.query_status]++;
					if (out_item.shear_velocity != want.shear_velocity)
						report_mismatch("shear_velocity", out_item.shear_velocity,
							want.shear_velocity);
					if (out_item.pressure_velocity != want.pressure_velocity)
						report_mismatch("pressure_velocity", out_item.pressure_velocity,
							want.pressure_velocity);
					if (out_item.density != want.density)
						report_mismatch("density", out_item.density, want.density);
					if (out_item.query_status != want.query_status)
						report_mismatch("query_status", out_item.query_status,
							want.query_status);
				end
			end
			if (hold_toggle != hold_seen) begin
				hold_seen <= hold_toggle;
				hold_left <= 400;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= r_idle_pct);
			end
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ORIGIN_X: cfg_origin_x = value;
			REG_ORIGIN_Y: cfg_origin_y = value;
			REG_DEPTH:    cfg_depth = value[22:0];
			REG_OUT_VS:   cfg_out_vs = value[23:0];
			REG_OUT_VP:   cfg_out_vp = value[23:0];
			REG_OUT_RHO:  cfg_out_rho = value[23:0];
			default: ;
		endcase
	endtask

	task automatic write_all_regs(input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] dl, input logic [31:0] ovs, input logic [31:0] ovp,
			input logic [31:0] orho);
		apb_write(REG_ORIGIN_X, ox);
		apb_write(REG_ORIGIN_Y, oy);
		apb_write(REG_DEPTH, dl);
		apb_write(REG_OUT_VS, ovs);
		apb_write(REG_OUT_VP, ovp);
		apb_write(REG_OUT_RHO, orho);
	endtask

	// Waits until everything is sent and answered, plus write latency
	task automatic drain;
		while (pending_items.size() != 0 || in_valid || predicted_props.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
	endtask

	function automatic in_item_t random_item(input logic [1:0] f);
		in_item_t it;
		logic [223:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		it.func = f;
		return it;
	endfunction

	task automatic push_node(input int unsigned idx, input int elev, input int unsigned cnt,
			input logic [15:0] first);
		in_item_t it;
		it = random_item(FUNC_NODE);
		it.entry_index = idx;
		it.node_elevation = elev;
		it.node_layer_count = cnt;
		it.node_first_layer = first;
		if (it.entry_index < NODE_COUNT) begin
			gen_node_ok[it.entry_index] = 1'b1;
			gen_cnt[it.entry_index] = (it.node_layer_count > MAX_LAYERS) ?
				MAX_LAYERS : it.node_layer_count;
			gen_start[it.entry_index] = 16'(first - 16'd1);
		end
		pending_items.push_back(it);
	endtask

	task automatic push_layer(input int unsigned idx, input int unsigned vs,
			input int unsigned rho, input int unsigned th);
		in_item_t it;
		it = random_item(FUNC_LAYER);
		it.entry_index = idx;
		it.layer_shear_velocity = vs;
		it.layer_density = rho;
		it.layer_thickness = th;
		gen_layer_ok[it.entry_index] = 1'b1;
		pending_items.push_back(it);
	endtask

	// Queries that would touch unwritten entries are lifted above the surface
	task automatic push_query(input longint unsigned x, input longint unsigned y,
			input int z);
		in_item_t it;
		int unsigned col, row, nd[4];
		longint unsigned wx, wy;
		bit unsafe;
		it = random_item(FUNC_QUERY);
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		unsafe = 1'b0;
		if (it.pos_z <= 0 && longint'(it.pos_z) >= -longint'(cfg_depth) &&
				locate_axis(it.pos_x, cfg_origin_x, GRID_COLUMNS, col, wx) &&
				locate_axis(it.pos_y, cfg_origin_y, GRID_ROWS, row, wy)) begin
			nd[0] = row * ROW_PITCH + col;
			nd[1] = nd[0] + 1;
			nd[2] = nd[1] + ROW_PITCH;
			nd[3] = nd[0] + ROW_PITCH;
			for (int i = 0; i < 4; i++) begin
				if (!gen_node_ok[nd[i]])
					unsafe = 1'b1;
				else
					for (int k = 0; k < gen_cnt[nd[i]]; k++)
						if (!gen_layer_ok[(gen_start[nd[i]] + k) % LAYER_STORE_DEPTH])
							unsafe = 1'b1;
			end
		end
		if (unsafe)
			it.pos_z = $urandom_range(1, 8388607);
		pending_items.push_back(it);
	endtask

	// First layer that keeps the walk inside the written layer pool
	function automatic logic [15:0] pool_first;
		int unsigned s;
		s = $urandom_range(0, 47);
		if ($urandom_range(0, 3) == 0)
			s = 32760 + $urandom_range(0, 7);
		s += 32768 * $urandom_range(0, 1);
		return 16'(s + 1);
	endfunction

	function automatic int unsigned pool_node;
		if ($urandom_range(0, 2) == 0)
			return (41 + $urandom_range(0, 1)) * ROW_PITCH + 103 + $urandom_range(0, 2);
		return $urandom_range(0, 2) * ROW_PITCH + $urandom_range(0, 3);
	endfunction

	function automatic int unsigned pool_layer;
		if ($urandom_range(0, 4) == 0)
			return 32760 + $urandom_range(0, 7);
		return $urandom_range(0, 63);
	endfunction

	function automatic int unsigned rand_value;
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 24'hFFFFFF;
			2: return $urandom_range(0, 24'hFFFFFF);
			default: return $urandom_range(1, 2000000);
		endcase
	endfunction

	function automatic longint unsigned cell_pos(input longint unsigned org, input int c);
		longint unsigned frac, p;
		case ($urandom_range(0, 5))
			0: frac = 0;
			1: frac = CELL_SIZE - 1;
			default: frac = $urandom_range(0, CELL_SIZE - 1);
		endcase
		p = org + longint'(c) * CELL_SIZE + frac;
		return (p > 64'hFFFFFFFF) ? longint'($urandom) : p;
	endfunction

	function automatic int rand_depth;
		case ($urandom_range(0, 9))
			0: return int'($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
			1: return -int'(cfg_depth);
			2: return 0;
			default: return -int'($urandom_range(0, cfg_depth));
		endcase
	endfunction

	task automatic random_phase(input int count);
		int c, r, sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 15) begin
				push_node(pool_node(), $urandom_range(0, 40000) - 20000,
					$urandom_range(0, 31), pool_first());
			end else if (sel < 30) begin
				push_layer(pool_layer(), rand_value(), rand_value(),
					$urandom_range(0, 40000));
			end else if (sel < 34) begin
				// stray writes: out of range nodes, layers at any index of the store
				if ($urandom_range(0, 1))
					push_node($urandom_range(NODE_COUNT, 32767), $urandom, $urandom,
						$urandom);
				else
					push_layer($urandom_range(0, 32767), $urandom, $urandom, $urandom);
			end else if (sel < 36) begin
				pending_items.push_back(random_item(2'd3));
			end else if (sel < 44) begin
				push_query($urandom, $urandom, rand_depth());
			end else if (sel < 50) begin
				push_query(cfg_origin_x + longint'(SPAN_X) - $urandom_range(0, 1),
					cfg_origin_y + longint'(SPAN_Y) - $urandom_range(0, 1), rand_depth());
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					c = 103 + $urandom_range(0, 1);
					r = 41;
				end else begin
					c = $urandom_range(0, 2);
					r = $urandom_range(0, 1);
				end
				push_query(cell_pos(cfg_origin_x, c), cell_pos(cfg_origin_y, r),
					rand_depth());
			end
		end
	endtask

	// Stimulus and phase sequencing
	initial begin
		longint unsigned ox, oy, ex, ey;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the layer pool and the node pool
		for (int i = 0; i < 64; i++)
			push_layer(i, rand_value(), rand_value(), $urandom_range(0, 40000));
		for (int i = 32760; i < 32768; i++)
			push_layer(i, rand_value(), rand_value(), $urandom_range(0, 40000));
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 4; c++)
				push_node(r * ROW_PITCH + c, $urandom_range(0, 40000) - 20000,
					$urandom_range(0, 16), pool_first());
		for (int r = 41; r < 43; r++)
			for (int c = 103; c < 106; c++)
				push_node(r * ROW_PITCH + c, $urandom_range(0, 40000) - 20000,
					$urandom_range(0, 16), pool_first());

		// Directed corner cases under reset settings
		ox = cfg_origin_x;
		oy = cfg_origin_y;
		ex = ox + SPAN_X;
		ey = oy + SPAN_Y;
		push_node(1 * ROW_PITCH + 1, 24'sh7FFFFF, 0, 16'd1);      // node without layers
		push_node(2 * ROW_PITCH + 2, -24'sd8388608, 31, 16'd0);   // count saturates, wrap
		push_node(NODE_COUNT, 0, 1, 16'd1);                       // ignored
		push_node(32767, 0, 1, 16'hFFFF);                         // ignored
		push_layer(32767, 0, 0, 24'hFFFFFF);
		pending_items.push_back(random_item(2'd3));
		push_query(ox, oy, 1);
		push_query(ox, oy, 24'sh7FFFFF);
		push_query(ox, oy, 0);
		push_query(ox + 64000, oy + 64000, -int'(cfg_depth));
		push_query(ox + 32000, oy + 32000, -int'(cfg_depth) - 1);
		push_query(ox - 1, oy, -100);
		push_query(ox, oy - 1, -100);
		push_query(ex, ey, -1000);
		push_query(ex + 1, ey, -1000);
		push_query(ex, ey + 1, -1000);
		push_query(ex - 1, ey - 1, -24'sd8388608);
		push_query(ox + 100000, oy + 20000, -5000);
		push_query(32'hFFFFFFFF, 32'hFFFFFFFF, -1);
		push_query(0, 0, -1);
		random_phase(75);
		drain();

		// Low origins, deepest limit, largest outside values; idles swapped
		s_idle_pct = 57;
		r_idle_pct = 12;
		write_all_regs(32'd0, 32'd0, 32'h7FFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF);
		push_query(SPAN_X, SPAN_Y, -24'sd8388607);
		push_query(0, 0, -24'sd8388608);
		random_phase(75);
		drain();

		// Highest origins, zero limit and zero outside values; no idling
		s_idle_pct = 0;
		r_idle_pct = 0;
		write_all_regs(32'hFFFFFFFF - SPAN_X, 32'hFFFFFFFF, 32'd0, 32'd0, 32'd0, 32'd0);
		push_query(32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		push_query(32'hFFFFFFFF, 32'hFFFFFFFE, 0);
		random_phase(60);
		drain();

		// Mid settings; long receiver hold-off while the sender keeps going
		s_idle_pct = 12;
		r_idle_pct = 57;
		write_all_regs($urandom_range(0, 32'h7FFFFFFF), $urandom_range(0, 32'h7FFFFFFF),
			$urandom_range(1000, 200000), $urandom_range(0, 24'hFFFFFF),
			$urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
		hold_toggle <= ~hold_toggle;
		random_phase(75);
		drain();

		$display("results checked: %0d above surface, %0d outside, %0d interpolated, %0d fallback",
			status_seen[QS_ABOVE], status_seen[QS_OUTSIDE], status_seen[QS_INTERP],
			status_seen[QS_FALLBACK]);
		$display("four register settings from reset to both extremes, %0d mismatches", errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
